>>> rtl/core/nrmc_pkg.sv
package nrmc_pkg;

   localparam int ZONE_W = 5;
   localparam logic [ZONE_W-1:0] ZONE_RESET = 5'd8;

   localparam int RSP_W = 136;

   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_S     = 8'h53;
   localparam logic [7:0] CHAR_W     = 8'h57;

   localparam logic [3:0] FLD_TIME   = 4'd1;
   localparam logic [3:0] FLD_STATUS = 4'd2;
   localparam logic [3:0] FLD_LAT    = 4'd3;
   localparam logic [3:0] FLD_NS     = 4'd4;
   localparam logic [3:0] FLD_LON    = 4'd5;
   localparam logic [3:0] FLD_EW     = 4'd6;
   localparam logic [3:0] FLD_SPEED  = 4'd7;
   localparam logic [3:0] FLD_COURSE = 4'd8;
   localparam logic [3:0] FLD_LAST   = 4'd9;
   localparam logic [3:0] POS_MAX    = 4'd15;

   // speed/course forms, by dot position
   localparam logic [1:0] FORM_P1 = 2'd0;
   localparam logic [1:0] FORM_P2 = 2'd1;
   localparam logic [1:0] FORM_P3 = 2'd2;
   localparam logic [5:0] ODD_MASK_P1 = 6'h1D;
   localparam logic [5:0] ODD_MASK_P2 = 6'h3B;
   localparam logic [5:0] ODD_MASK_P3 = 6'h37;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_NO_COMMA = 2'd1;
   localparam logic [1:0] STAT_FORMAT   = 2'd2;

   // ceil(2^26 / 5): exact floor(x/5) for x below 2^24
   localparam logic [23:0] DIV5_RECIP = 24'hCCCCCD;

   typedef struct packed {
      logic [3:0]        field_num;
      logic [3:0]        char_pos;
      logic [6:0]        hour;
      logic [13:0]       rest;
      logic [6:0]        lat_deg;
      logic [23:0]       lat_min;
      logic [9:0]        lon_deg;
      logic [23:0]       lon_min;
      logic [2:0][25:0]  spd_acc;   // candidate forms, times 37
      logic [2:0][19:0]  crs_acc;
      logic [2:0]        spd_dots;
      logic [2:0]        crs_dots;
      logic [5:0]        spd_odd;
      logic [5:0]        crs_odd;
      logic              lat_dot;
      logic              lon_dot;
      logic              time_bad;
      logic              lat_bad;
      logic              lon_bad;
      logic              stat_a;
      logic              south;
      logic              west;
   } parse_state_type;

   function automatic logic [23:0] digit_weight(input logic [3:0] fld, input logic [3:0] p);
      logic [23:0] w;
      w = 24'd0;
      case (fld)
         FLD_TIME: begin
            case (p)
               4'd0: w = 24'd10;
               4'd1: w = 24'd1;
               4'd2: w = 24'd1000;
               4'd3: w = 24'd100;
               4'd4: w = 24'd10;
               4'd5: w = 24'd1;
               default: w = 24'd0;
            endcase
         end
         FLD_LAT: begin
            case (p)
               4'd0: w = 24'd10;
               4'd1: w = 24'd1;
               4'd2: w = 24'd1000000;
               4'd3: w = 24'd100000;
               4'd5: w = 24'd10000;
               4'd6: w = 24'd1000;
               4'd7: w = 24'd100;
               4'd8: w = 24'd10;
               4'd9: w = 24'd1;
               default: w = 24'd0;
            endcase
         end
         FLD_LON: begin
            case (p)
               4'd0: w = 24'd100;
               4'd1: w = 24'd10;
               4'd2: w = 24'd1;
               4'd3: w = 24'd1000000;
               4'd4: w = 24'd100000;
               4'd6: w = 24'd10000;
               4'd7: w = 24'd1000;
               4'd8: w = 24'd100;
               4'd9: w = 24'd10;
               4'd10: w = 24'd1;
               default: w = 24'd0;
            endcase
         end
         default: w = 24'd0;
      endcase
      return w;
   endfunction

   function automatic logic [19:0] form_weight(input logic [1:0] f, input logic [3:0] p);
      logic [19:0] w;
      w = 20'd0;
      case (f)
         FORM_P1: begin
            case (p)
               4'd0: w = 20'd1000;
               4'd2: w = 20'd100;
               4'd3: w = 20'd10;
               4'd4: w = 20'd1;
               default: w = 20'd0;
            endcase
         end
         FORM_P2: begin
            case (p)
               4'd0: w = 20'd10000;
               4'd1: w = 20'd1000;
               4'd3: w = 20'd100;
               4'd4: w = 20'd10;
               4'd5: w = 20'd1;
               default: w = 20'd0;
            endcase
         end
         FORM_P3: begin
            case (p)
               4'd0: w = 20'd100000;
               4'd1: w = 20'd10000;
               4'd2: w = 20'd1000;
               4'd4: w = 20'd100;
               4'd5: w = 20'd10;
               default: w = 20'd0;
            endcase
         end
         default: w = 20'd0;
      endcase
      return w;
   endfunction

   function automatic logic [25:0] speed_weight(input logic [1:0] f, input logic [3:0] p);
      return 26'(form_weight(f, p)) * 26'd37;
   endfunction

   function automatic logic [4:0] mod24(input logic [7:0] s);
      logic [7:0] r;
      r = s;
      for (int i = 0; i < 5; i++) begin
         if (r >= 8'd24) begin
            r = r - 8'd24;
         end
      end
      return r[4:0];
   endfunction

endpackage

>>> rtl/core/nrmc_byte_decoder.sv
module nrmc_byte_decoder (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      take,
   input  logic [7:0]                char_in,
   input  logic                      last_in,
   input  logic                      snap_pop,
   output logic                      snap_vld,
   output nrmc_pkg::parse_state_type snap
);
   import nrmc_pkg::*;

   parse_state_type st_ff, st_in;
   parse_state_type snap_ff;
   logic            snap_vld_ff;

   logic            dig;
   logic [3:0]      dv;
   logic [3:0]      p;
   logic [27:0]     prod;
   logic [2:0][29:0] spd_add;
   logic [2:0][23:0] crs_add;

   assign dig = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
   assign dv  = dig ? char_in[3:0] : 4'd0;
   assign p   = st_ff.char_pos;
   assign prod = 28'(dv) * 28'(digit_weight(st_ff.field_num, p));

   always_comb begin
      for (int f = 0; f < 3; f++) begin
         spd_add[f] = 30'(dv) * 30'(speed_weight(2'(f), p));
         crs_add[f] = 24'(dv) * 24'(form_weight(2'(f), p));
      end
   end

   always_comb begin
      st_in = st_ff;
      if (char_in == CHAR_COMMA) begin
         if (st_ff.field_num < FLD_LAST) begin
            st_in.field_num = st_ff.field_num + 4'd1;
         end
         st_in.char_pos = 4'd0;
      end else begin
         case (st_ff.field_num)
            FLD_TIME: begin
               if (p < 4'd6) begin
                  if (p < 4'd2) st_in.hour = st_ff.hour + prod[6:0];
                  else st_in.rest = st_ff.rest + prod[13:0];
                  if (!dig) st_in.time_bad = 1'b1;
               end
            end
            FLD_STATUS: begin
               if (p == 4'd0 && char_in == CHAR_A) st_in.stat_a = 1'b1;
            end
            FLD_LAT: begin
               if (char_in == CHAR_DOT) st_in.lat_dot = 1'b1;
               if (p < 4'd10 && p != 4'd4) begin
                  if (p < 4'd2) st_in.lat_deg = st_ff.lat_deg + prod[6:0];
                  else st_in.lat_min = st_ff.lat_min + prod[23:0];
                  if (!dig) st_in.lat_bad = 1'b1;
               end
            end
            FLD_NS: begin
               if (p == 4'd0 && char_in == CHAR_S) st_in.south = 1'b1;
            end
            FLD_LON: begin
               if (char_in == CHAR_DOT) st_in.lon_dot = 1'b1;
               if (p < 4'd11 && p != 4'd5) begin
                  if (p < 4'd3) st_in.lon_deg = st_ff.lon_deg + prod[9:0];
                  else st_in.lon_min = st_ff.lon_min + prod[23:0];
                  if (!dig) st_in.lon_bad = 1'b1;
               end
            end
            FLD_EW: begin
               if (p == 4'd0 && char_in == CHAR_W) st_in.west = 1'b1;
            end
            FLD_SPEED: begin
               if (p < 4'd6) begin
                  for (int f = 0; f < 3; f++) begin
                     st_in.spd_acc[f] = st_ff.spd_acc[f] + spd_add[f][25:0];
                  end
                  if (!dig) st_in.spd_odd[p[2:0]] = 1'b1;
                  if (char_in == CHAR_DOT && p >= 4'd1 && p <= 4'd3) begin
                     st_in.spd_dots[p[1:0] - 2'd1] = 1'b1;
                  end
               end
            end
            FLD_COURSE: begin
               if (p < 4'd6) begin
                  for (int f = 0; f < 3; f++) begin
                     st_in.crs_acc[f] = st_ff.crs_acc[f] + crs_add[f][19:0];
                  end
                  if (!dig) st_in.crs_odd[p[2:0]] = 1'b1;
                  if (char_in == CHAR_DOT && p >= 4'd1 && p <= 4'd3) begin
                     st_in.crs_dots[p[1:0] - 2'd1] = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
         if (p < POS_MAX) begin
            st_in.char_pos = p + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= '0;
         snap_vld_ff <= 1'b0;
      end else begin
         if (take) begin
            st_ff <= last_in ? '0 : st_in;
         end
         if (take && last_in) begin
            snap_vld_ff <= 1'b1;
         end else if (snap_pop) begin
            snap_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && last_in) begin
         snap_ff <= st_in;
      end
   end

   assign snap_vld = snap_vld_ff;
   assign snap     = snap_ff;

endmodule

>>> rtl/core/nrmc_result_builder.sv
module nrmc_result_builder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  nrmc_pkg::parse_state_type     snap,
   input  logic [nrmc_pkg::ZONE_W-1:0]   zone,
   input  logic                          rsp_tready,
   output logic                          rsp_vld,
   output logic [nrmc_pkg::RSP_W-1:0]    rsp_data
);
   import nrmc_pkg::*;

   logic             rsp_vld_ff;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic        spd_err, crs_err, err;
   logic [25:0] spd37;
   logic [19:0] crs;
   logic [47:0] spd_prod;
   logic [20:0] spd;
   logic [4:0]  lh;
   logic [17:0] ltime;
   logic [1:0]  status;
   logic        fix;

   always_comb begin
      spd37   = 26'd0;
      spd_err = 1'b0;
      if (snap.spd_dots[FORM_P2]) begin
         spd37   = snap.spd_acc[FORM_P2];
         spd_err = |(snap.spd_odd & ODD_MASK_P2);
      end else if (snap.spd_dots[FORM_P1]) begin
         spd37   = snap.spd_acc[FORM_P1];
         spd_err = |(snap.spd_odd & ODD_MASK_P1);
      end else if (snap.spd_dots[FORM_P3]) begin
         spd37   = snap.spd_acc[FORM_P3];
         spd_err = |(snap.spd_odd & ODD_MASK_P3);
      end
   end

   always_comb begin
      crs     = 20'd0;
      crs_err = 1'b0;
      if (snap.crs_dots[FORM_P2]) begin
         crs     = snap.crs_acc[FORM_P2];
         crs_err = |(snap.crs_odd & ODD_MASK_P2);
      end else if (snap.crs_dots[FORM_P1]) begin
         crs     = snap.crs_acc[FORM_P1];
         crs_err = |(snap.crs_odd & ODD_MASK_P1);
      end else if (snap.crs_dots[FORM_P3]) begin
         crs     = snap.crs_acc[FORM_P3];
         crs_err = |(snap.crs_odd & ODD_MASK_P3);
      end
   end

   // knots*1.85 = (knots*37)/20, taken as (x/4)/5
   assign spd_prod = 48'(spd37[25:2]) * 48'(DIV5_RECIP);
   assign spd      = spd_prod[46:26];

   assign lh    = mod24(8'(snap.hour) + 8'(zone));
   assign ltime = 18'(lh) * 18'd10000 + 18'(snap.rest);

   assign err = snap.time_bad | (snap.lat_bad & snap.lat_dot) | (snap.lon_bad & snap.lon_dot)
              | spd_err | crs_err;

   always_comb begin
      if (snap.field_num < FLD_LAST) status = STAT_NO_COMMA;
      else if (err) status = STAT_FORMAT;
      else status = STAT_OK;
   end

   assign fix = snap.stat_a & snap.lat_dot & snap.lon_dot;

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[1:0] = status;
      if (status == STAT_OK) begin
         rsp_data_in[2]       = fix;
         rsp_data_in[20:3]    = ltime;
         rsp_data_in[27:21]   = snap.lat_deg;
         rsp_data_in[51:28]   = snap.lat_min;
         rsp_data_in[61:52]   = snap.lon_deg;
         rsp_data_in[85:62]   = snap.lon_min;
         rsp_data_in[87:86]   = {snap.west, snap.south};
         rsp_data_in[108:88]  = spd;
         rsp_data_in[128:109] = crs;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (load) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_vld  = rsp_vld_ff;
   assign rsp_data = rsp_data_ff;

endmodule

>>> rtl/core/nmea_rmc_field_extractor_unit.sv
// One byte word accepted per cycle while the result path is not held by rsp_tready, no gaps between sentences.
// After the word marked last is accepted, the result word passes through
// the sentence snapshot register, then the result register with the speed scaling multiplier.
// Synchronous active-high reset clears the parse state and both stages;
// the zone offset returns to 8 hours.
module nmea_rmc_field_extractor_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,   // sentence_byte
   input  logic                        req_tlast,   // last_byte
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // parse_status, fix_valid, local_time, lat_degrees, lat_minutes_e5, lon_degrees,
   // lon_minutes_e5, hemisphere_bits, speed_kmh_milli, course_milli_deg, zero pad
   output logic [nrmc_pkg::RSP_W-1:0]  rsp_tdata,
   input  logic                        csr_wen,
   input  logic [nrmc_pkg::ZONE_W-1:0] csr_wdata  // zone_offset_hours
);
   import nrmc_pkg::*;

   logic [ZONE_W-1:0] zone_ff;
   logic              take;
   logic              snap_vld;
   logic              snap_pop;
   parse_state_type   snap;

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff <= ZONE_RESET;
      end else if (csr_wen) begin
         zone_ff <= csr_wdata;
      end
   end

   assign snap_pop   = snap_vld && (!rsp_tvalid || rsp_tready);
   assign req_tready = !snap_vld || snap_pop;
   assign take       = req_tvalid && req_tready;

   nrmc_byte_decoder u_dec (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .char_in  (req_tdata),
      .last_in  (req_tlast),
      .snap_pop (snap_pop),
      .snap_vld (snap_vld),
      .snap     (snap)
   );

   nrmc_result_builder u_res (
      .clock      (clock),
      .reset      (reset),
      .load       (snap_pop),
      .snap       (snap),
      .zone       (zone_ff),
      .rsp_tready (rsp_tready),
      .rsp_vld    (rsp_tvalid),
      .rsp_data   (rsp_tdata)
   );

endmodule

>>> rtl/core/nrmc_checker.sv
module nrmc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic                       req_tlast,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [nrmc_pkg::RSP_W-1:0] rsp_tdata
);
   import nrmc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] == STAT_OK || rsp_tdata[1:0] == STAT_NO_COMMA ||
                      rsp_tdata[1:0] == STAT_FORMAT))
      else $error("bad status code");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != STAT_OK |-> rsp_tdata[RSP_W-1:2] == '0)
      else $error("error result carries data");

   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tlast, 2))
      else $error("result without a last word two cycles earlier");

endmodule

bind nmea_rmc_field_extractor_unit nrmc_checker u_nrmc_checker (.*);
